// ===== hdl/mcn_pkg.sv =====
// Shared types, coefficients and mode codes of the multichannel notch filter.
`default_nettype none

package mcn_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_W   = 16;
  localparam int CH_W       = 4;
  localparam int Y_W        = 32;
  localparam int MODE_W     = 2;
  localparam int FRAC_BITS  = 14;

  // Default number of channels served in round-robin order.
  localparam int CHANNELS_DEF = 12;

  // Mode register codes; the code left over acts as pass-through.
  localparam logic [MODE_W-1:0] MODE_60HZ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_50HZ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd2;

  // Biquad coefficients in Q2.14.
  localparam logic signed [15:0] COEF_B0    = 16'sd15886;
  localparam logic signed [15:0] COEF_A2    = 16'sd15386;
  localparam logic signed [15:0] COEF_B1_60 = 16'sd29540;
  localparam logic signed [15:0] COEF_A1_60 = 16'sd29539;
  localparam logic signed [15:0] COEF_B1_50 = 16'sd30217;
  localparam logic signed [15:0] COEF_A1_50 = 16'sd30215;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [Y_W-1:0]      yval_t;

  // Per-channel history: two past inputs and two past outputs (Q18.14).
  typedef struct packed {
    sample_t x_old;
    sample_t x_new;
    yval_t   y_old;
    yval_t   y_new;
  } hist_t;

  // Result of the filter arithmetic for one word.
  typedef struct packed {
    yval_t   y;
    sample_t filtered;
    logic    clip;
  } mac_res_t;

endpackage

`default_nettype wire

// ===== hdl/mcn_sample_if.sv =====
// Stream interface that carries raw amplifier samples.
`default_nettype none

interface mcn_sample_if import mcn_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcn_result_if.sv =====
// Stream interface that carries filtered results with their channel index.
`default_nettype none

interface mcn_result_if import mcn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel;
  sample_t         filtered;
  logic            clipped;

  modport source (output valid, output channel, output filtered, output clipped, input ready);
  modport sink   (input valid, input channel, input filtered, input clipped, output ready);
endinterface

`default_nettype wire

// ===== hdl/mcn_hist_mem.sv =====
// Per-channel history memory with registered read and per-entry valid bits.
`default_nettype none

module mcn_hist_mem import mcn_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   rd_en_i,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr_i,
  output hist_t                                       rd_data_o,
  input  wire logic                                   wr_en_i,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr_i,
  input  wire hist_t                                  wr_data_i
);

  hist_t               mem [CHANNELS];
  logic [CHANNELS-1:0] written_q;
  hist_t               rd_q;
  logic                rd_valid_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // An entry that was never written since reset reads as zero history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= written_q[rd_addr_i];
      end
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hdl/mcn_mac.sv =====
// Biquad arithmetic: registered products, then sum, shift and saturation.
`default_nettype none

module mcn_mac import mcn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    load_i,
  input  wire logic    sel50_i,
  input  wire hist_t   hist_i,
  input  wire sample_t sample_i,
  output mac_res_t     res_o
);

  logic signed [31:0] pb0x0_q, pb1x1_q, pb0x2_q;
  logic signed [47:0] pa2y0_q, pa1y1_q;
  logic signed [15:0] coef_b1, coef_a1;

  // Coefficient pair for the selected notch frequency.
  assign coef_b1 = sel50_i ? COEF_B1_50 : COEF_B1_60;
  assign coef_a1 = sel50_i ? COEF_A1_50 : COEF_A1_60;

  // Product stage, loaded when the word moves into the sum stage.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pb0x0_q <= 32'(hist_i.x_old) * 32'(COEF_B0);
      pb1x1_q <= 32'(hist_i.x_new) * 32'(coef_b1);
      pb0x2_q <= 32'(sample_i) * 32'(COEF_B0);
      pa2y0_q <= 48'(hist_i.y_old) * 48'(COEF_A2);
      pa1y1_q <= 48'(hist_i.y_new) * 48'(coef_a1);
    end
  end

  logic signed [33:0] x_sum;
  logic signed [48:0] r_sum;
  logic signed [34:0] r_sh;
  logic signed [35:0] y_full;
  yval_t              y_sat;
  logic               y_clip;
  logic signed [17:0] whole;
  logic signed [17:0] whole_tz;
  sample_t            out_sat;
  logic               out_clip;

  // The feed-forward sum is already in Q14 units, so only the feedback part
  // needs the floor shift; floor(a*2^14 + r) >> 14 equals a + (r >>> 14).
  always_comb begin
    x_sum  = 34'(pb0x0_q) - 34'(pb1x1_q) + 34'(pb0x2_q);
    r_sum  = 49'(pa1y1_q) - 49'(pa2y0_q);
    r_sh   = 35'(r_sum >>> FRAC_BITS);
    y_full = 36'(x_sum) + 36'(r_sh);

    y_clip = 1'b0;
    if (y_full > 36'sd2147483647) begin
      y_sat  = 32'sh7FFFFFFF;
      y_clip = 1'b1;
    end else if (y_full < -36'sd2147483648) begin
      y_sat  = 32'sh80000000;
      y_clip = 1'b1;
    end else begin
      y_sat  = 32'(y_full);
    end

    // Integer part, rounded toward zero.
    whole = 18'(y_sat >>> FRAC_BITS);
    if (y_sat[Y_W-1] && (|y_sat[FRAC_BITS-1:0])) begin
      whole_tz = whole + 18'sd1;
    end else begin
      whole_tz = whole;
    end

    out_clip = 1'b0;
    if (whole_tz > 18'sd32767) begin
      out_sat  = 16'sh7FFF;
      out_clip = 1'b1;
    end else if (whole_tz < -18'sd32768) begin
      out_sat  = 16'sh8000;
      out_clip = 1'b1;
    end else begin
      out_sat  = 16'(whole_tz);
    end
  end

  assign res_o.y        = y_sat;
  assign res_o.filtered = out_sat;
  assign res_o.clip     = y_clip | out_clip;

endmodule

`default_nettype wire

// ===== hdl/multichannel_iir_notch_filter.sv =====
// Multichannel 50/60 Hz biquad notch filter: top level with pipeline control.
//
// Samples arrive on sample_i, one word per converted sample; the block
// assigns them to channels 0..CHANNELS-1 in round-robin order and returns one
// word per sample on result_o, carrying the channel, the filtered value and a
// clip flag. cfg_we_i/cfg_wdata_i write the mode: 60 Hz notch, 50 Hz notch,
// or pass-through (the unused code also passes through and history is kept).
// Write the mode only while the block is empty.
// A word moves through registered steps: history read at the accepting edge,
// then products, then sum/saturation into the output register. Throughput is
// one word per cycle for CHANNELS of three or more while result_o does not
// stall. A word is held back while the same channel is still in flight
// (history read-after-write interlock), so with one or two channels the block
// takes a word only after its channel's last word has left the sum stage.
// Reset clears the channel counter, the mode and the per-channel history
// valid bits, so every channel starts from zero history at once.
// When result_o stalls, the pipeline keeps filling its empty stages and
// sample_i drops ready once every stage holds a word (or on the interlock).
`default_nettype none

module multichannel_iir_notch_filter import mcn_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [MODE_W-1:0]  cfg_wdata_i,
  mcn_sample_if.sink              sample_i,
  mcn_result_if.source            result_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [MODE_W-1:0] notch_mode_q;
  logic [CH_W-1:0]   ch_q, ch_d;

  logic              s1_valid_q, s1_filt_q, s1_sel50_q;
  logic [CH_W-1:0]   s1_ch_q;
  sample_t           s1_sample_q;

  logic              s2_valid_q, s2_filt_q;
  logic [CH_W-1:0]   s2_ch_q;
  sample_t           s2_sample_q, s2_x1_q;
  yval_t             s2_y1_q;

  logic              out_valid_q, out_clip_q;
  logic [CH_W-1:0]   out_ch_q;
  sample_t           out_filtered_q;

  logic              out_adv, s2_adv, s1_adv, hazard, accept, wb_en;
  hist_t             rd_hist, wb_hist;
  mac_res_t          mac_res;

  // Stage advance: a stage may load when it is empty or its word moves on.
  assign out_adv = !out_valid_q || result_o.ready;
  assign s2_adv  = !s2_valid_q || out_adv;
  assign s1_adv  = !s1_valid_q || s2_adv;

  // Hold a word back while its channel's history is still being updated.
  assign hazard = (s1_valid_q && (s1_ch_q == ch_q)) || (s2_valid_q && (s2_ch_q == ch_q));

  assign sample_i.ready = s1_adv && !hazard;
  assign accept         = sample_i.valid && sample_i.ready;

  // Round-robin channel counter.
  always_comb begin
    if (({1'b0, ch_q} + 5'd1) >= 5'(CHANNELS)) begin
      ch_d = '0;
    end else begin
      ch_d = ch_q + CH_W'(1);
    end
  end

  // Mode register and channel counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notch_mode_q <= MODE_60HZ;
      ch_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        notch_mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        ch_q <= ch_d;
      end
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= accept;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q     <= ch_q;
      s1_sample_q <= sample_i.sample;
      s1_filt_q   <= (notch_mode_q == MODE_60HZ) || (notch_mode_q == MODE_50HZ);
      s1_sel50_q  <= (notch_mode_q == MODE_50HZ);
    end
    if (s2_adv && s1_valid_q) begin
      s2_ch_q     <= s1_ch_q;
      s2_sample_q <= s1_sample_q;
      s2_filt_q   <= s1_filt_q;
      s2_x1_q     <= rd_hist.x_new;
      s2_y1_q     <= rd_hist.y_new;
    end
    if (out_adv && s2_valid_q) begin
      out_ch_q       <= s2_ch_q;
      out_filtered_q <= s2_filt_q ? mac_res.filtered : s2_sample_q;
      out_clip_q     <= s2_filt_q & mac_res.clip;
    end
  end

  // History write-back as a filtered word leaves the sum stage.
  assign wb_en         = out_adv && s2_valid_q && s2_filt_q;
  assign wb_hist.x_old = s2_x1_q;
  assign wb_hist.x_new = s2_sample_q;
  assign wb_hist.y_old = s2_y1_q;
  assign wb_hist.y_new = mac_res.y;

  mcn_hist_mem #(
    .CHANNELS (CHANNELS)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (ch_q[AW-1:0]),
    .rd_data_o (rd_hist),
    .wr_en_i   (wb_en),
    .wr_addr_i (s2_ch_q[AW-1:0]),
    .wr_data_i (wb_hist)
  );

  mcn_mac u_mac (
    .clk_i    (clk_i),
    .load_i   (s2_adv && s1_valid_q),
    .sel50_i  (s1_sel50_q),
    .hist_i   (rd_hist),
    .sample_i (s1_sample_q),
    .res_o    (mac_res)
  );

  // Output register drives the result stream.
  assign result_o.valid    = out_valid_q;
  assign result_o.channel  = out_ch_q;
  assign result_o.filtered = out_filtered_q;
  assign result_o.clipped  = out_clip_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench of the multichannel notch filter: streaming stimulus with bit-exact result checks.
module tb;
  import mcn_pkg::*;

  localparam int NCH             = CHANNELS_DEF;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int NUM_PHASES      = 8;
  localparam int RUN_LEN         = 48;
  localparam int HOLD_CYCLES     = 60;
  localparam int HOLD_MARK_A     = 500;
  localparam int HOLD_MARK_B     = 1700;
  localparam int DRAIN_PAD       = 8;

  // The mode code that the package leaves unnamed; it behaves as pass-through.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam longint Y_MAX = (longint'(1) <<< 31) - 1;
  localparam longint Y_MIN = -(longint'(1) <<< 31);
  localparam longint OUT_MAX = 32767;
  localparam longint OUT_MIN = -32768;

  typedef enum int {KIND_FULL, KIND_EXTREME, KIND_SMALL, KIND_NYQUIST} sample_kind_e;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    sample_t         filtered;
    logic            clipped;
  } notch_word_t;

  // Tracks the filter state per channel and holds the result words still to come.
  class notch_scoreboard;
    logic [MODE_W-1:0] mode;
    int                chan_ctr;
    sample_t           x_hist[2*NCH];
    yval_t             y_hist[2*NCH];
    notch_word_t       expected_q[$];
    int                errors;

    function new();
      mode     = MODE_60HZ;
      chan_ctr = 0;
      errors   = 0;
      foreach (x_hist[k]) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
    endfunction

    function void set_mode(logic [MODE_W-1:0] m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out the result word of an accepted sample and advances the channel history.
    function void note_sample(sample_t s);
      notch_word_t w;
      longint b0, a2, b1, a1, x0, x1, x2, y0, y1, acc, y, whole;
      int c;
      c = (chan_ctr >= NCH) ? 0 : chan_ctr;
      w.channel  = CH_W'(c);
      w.filtered = s;
      w.clipped  = 1'b0;
      if (mode == MODE_60HZ || mode == MODE_50HZ) begin
        b0 = COEF_B0;
        a2 = COEF_A2;
        if (mode == MODE_60HZ) begin
          b1 = COEF_B1_60;
          a1 = COEF_A1_60;
        end else begin
          b1 = COEF_B1_50;
          a1 = COEF_A1_50;
        end
        x0 = x_hist[2*c];
        x1 = x_hist[2*c+1];
        x2 = s;
        y0 = y_hist[2*c];
        y1 = y_hist[2*c+1];
        // Feed-forward part lifted to Q28, then the feedback terms; the shift floors.
        acc = (b0 * x0 - b1 * x1 + b0 * x2) * 16384 - a2 * y0 + a1 * y1;
        y = acc >>> FRAC_BITS;
        if (y > Y_MAX) begin
          y = Y_MAX;
          w.clipped = 1'b1;
        end
        if (y < Y_MIN) begin
          y = Y_MIN;
          w.clipped = 1'b1;
        end
        x_hist[2*c]   = x_hist[2*c+1];
        x_hist[2*c+1] = s;
        y_hist[2*c]   = y_hist[2*c+1];
        y_hist[2*c+1] = yval_t'(y);
        // Integer part truncated toward zero, then saturated to 16 bits.
        whole = y / 16384;
        if (whole > OUT_MAX) begin
          whole = OUT_MAX;
          w.clipped = 1'b1;
        end
        if (whole < OUT_MIN) begin
          whole = OUT_MIN;
          w.clipped = 1'b1;
        end
        w.filtered = sample_t'(whole);
      end
      expected_q.push_back(w);
      chan_ctr = (c + 1 >= NCH) ? 0 : c + 1;
    endfunction

    // Compares an accepted result word with the oldest expected one.
    function void check_result(logic [CH_W-1:0] ch, sample_t filt, logic clip);
      notch_word_t w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: channel %0d filtered %0d clipped %0d",
               ch, filt, clip);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (ch !== w.channel) begin
        $error("channel: expected %0d, actual %0d", w.channel, ch);
        errors++;
      end
      if (filt !== w.filtered) begin
        $error("filtered: expected %0d, actual %0d", w.filtered, filt);
        errors++;
      end
      if (clip !== w.clipped) begin
        $error("clipped: expected %0d, actual %0d", w.clipped, clip);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                in_count = 0;
  notch_scoreboard   sb;

  mcn_sample_if sample_bus ();
  mcn_result_if result_bus ();

  multichannel_iir_notch_filter #(
    .CHANNELS(NCH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_bus),
    .result_o   (result_bus)
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watches both handshakes at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (sample_bus.valid && sample_bus.ready) begin
        sb.note_sample(sample_bus.sample);
        in_count <= in_count + 1;
      end
      if (result_bus.valid && result_bus.ready) begin
        sb.check_result(result_bus.channel, result_bus.filtered, result_bus.clipped);
      end
    end
  end

  // Result side: random back-pressure, plus a long hold-off at two points of the run.
  initial begin : rx_drive
    int hold_left;
    int held_at;
    hold_left = 0;
    held_at   = -1;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && in_count != held_at &&
          (in_count == HOLD_MARK_A || in_count == HOLD_MARK_B)) begin
        held_at   = in_count;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one sample word, with random idle cycles ahead of it.
  task automatic send_sample(input sample_t s);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      sample_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    do @(posedge clk_i); while (!sample_bus.ready);
  endtask

  // Stops offering and waits until every expected word has come back.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  // Sample content for the random part; the Nyquist kind flips sign on every
  // visit of a channel, which drives the notch just past unity gain.
  function automatic sample_t pick_sample(sample_kind_e kind, int k);
    case (kind)
      KIND_EXTREME: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      KIND_SMALL:   return sample_t'(int'($urandom_range(510)) - 255);
      KIND_NYQUIST: return ((k / NCH) % 2 == 1) ? 16'sh7FFF : 16'sh8000;
      default:      return sample_t'($urandom);
    endcase
  endfunction

  // Main sequence: reset, directed words, then phases under each mode.
  initial begin : main_seq
    logic [MODE_W-1:0] phase_mode [NUM_PHASES];
    sample_kind_e      kind;
    phase_mode = '{MODE_50HZ, MODE_60HZ, MODE_BYPASS, MODE_SPARE,
                   MODE_60HZ, MODE_50HZ, MODE_BYPASS, MODE_60HZ};
    kind = KIND_FULL;
    sb = new();
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = MODE_60HZ;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    tx_idle_pct       = 22;
    rx_idle_pct       = 64;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset mode: a full-scale step on every channel,
    // which overshoots and saturates the output.
    for (int k = 0; k < NCH; k++) send_sample(16'sh8000);
    for (int k = 0; k < NCH; k++) send_sample(16'sh7FFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 64;
      end else if (p < 6) begin
        tx_idle_pct = 64;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain_results();
      write_mode(phase_mode[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % RUN_LEN == 0) kind = sample_kind_e'($urandom_range(3));
        send_sample(pick_sample(kind, k));
      end
    end

    drain_results();
    repeat (DRAIN_PAD) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
